// ----- src/rrb_pkg.sv -----
// Package for the RMS norm row backward block: payload structs and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rrb_pkg;

  localparam int unsigned ValueWidth = 16;
  localparam int unsigned GradWidth  = 32;
  localparam int unsigned EpsWidth   = 16;
  localparam int unsigned LenWidth   = 7;
  localparam int unsigned SqWidth    = 37;
  localparam int unsigned DotWidth   = 38;

  localparam logic [LenWidth-1:0] LenReset = 7'd64;
  localparam logic [EpsWidth-1:0] EpsReset = 16'd17;

  typedef enum logic {
    REG_ROW_LENGTH = 1'b0,
    REG_EPS_SCALED = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] x_value;
    logic signed [ValueWidth-1:0] grad_value;
  } in_t;

  typedef struct packed {
    logic signed [GradWidth-1:0] grad_in;
    logic                        last_of_row;
  } out_t;

endpackage
`default_nettype wire

// ----- src/rmsnorm_row_backward.sv -----
// RMS norm backward pass over one row, built on one shared divider and a root unit.
// Depends on rrb_pkg.
//
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_stall  | rrb_pkg::in_t  (x_value, grad_value)
//  out     | out | out_valid/out_stall| rrb_pkg::out_t (grad_in, last_of_row)
//  cfg     | in  | cfg_write          | cfg_index, cfg_data
//
// Each pair goes through accept, square and dot product; in_stall holds off the next pair until idle.
// At row end: v, the mean divide and the root, then per element read, two
// multiplies, two divides and transfer (a zero v or root skips to the transfer).
// The iterative divider sets the per-element time. rst is synchronous; the stores
// need no clearing. A stalled output holds the sequencer in its transfer step.
`timescale 1ns / 1ps
`default_nettype none
module rmsnorm_row_backward #(
  parameter int unsigned MAX_FEATURES = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire rrb_pkg::in_t         in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output rrb_pkg::out_t             out_data,
  input  wire logic                 cfg_write,
  input  wire logic                 cfg_index,
  input  wire logic [rrb_pkg::EpsWidth-1:0] cfg_data
);

  localparam int unsigned CW = $clog2(MAX_FEATURES + 1);
  localparam int unsigned IW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned VW = rrb_pkg::SqWidth;
  localparam int unsigned DW = rrb_pkg::DotWidth;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_FEATURES);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_DOT, S_VCALC, S_NDIV, S_SQRT, S_RD, S_RDW,
    S_MUL1, S_MUL2, S_EDIV, S_GDIV, S_PUT
  } state_t;

  state_t state;

  logic [rrb_pkg::LenWidth-1:0] row_length;
  logic [rrb_pkg::EpsWidth-1:0] eps_scaled;

  logic [2*rrb_pkg::ValueWidth-1:0] mem [MAX_FEATURES];
  logic [2*rrb_pkg::ValueWidth-1:0] rd_data;

  logic signed [15:0] xr, gr;
  logic [VW-1:0] sum_squares;
  logic signed [DW-1:0] dot_sum;
  logic [CW-1:0] fill_count, n, k;
  logic [VW-1:0] v;
  logic [31:0] s;

  // divider
  logic [63:0] dv_num, dv_quo;
  logic [39:0] dv_den, dv_rem;
  logic [6:0]  dv_cnt;
  logic [40:0] dv_sh;
  logic        dv_ge;

  // root
  logic [63:0] sq_rad;
  logic [34:0] sq_rem, sq_sh;
  logic [33:0] sq_trial;
  logic        sq_ge;

  logic signed [53:0] p_gv;
  logic signed [54:0] t;
  logic        neg;
  logic [39:0] e_mag;

  logic [CW-1:0] eff;
  logic [CW-1:0] cnt_inc;
  logic signed [15:0] xm, gm;
  logic signed [31:0] sq_prod;
  logic signed [31:0] dot_prod;
  logic signed [53:0] xd_prod;
  logic signed [54:0] t_next;
  logic [62:0] t_mag;
  logic [63:0] t_abs;
  logic signed [31:0] g_sat;

  always_comb begin
    if (row_length == '0) begin
      eff = CW'(1);
    end else if ({{(CW > 7 ? CW - 7 : 0){1'b0}}, row_length} > MaxCount) begin
      eff = MaxCount;
    end else begin
      eff = CW'(row_length);
    end
    cnt_inc  = fill_count + CW'(1);
    xm       = $signed(rd_data[31:16]);
    gm       = $signed(rd_data[15:0]);
    sq_prod  = xr * xr;
    dot_prod = gr * xr;
    xd_prod  = xm * dot_sum;
    t_next   = 55'(p_gv) - 55'(xd_prod);
    t_abs    = t[54] ? 64'(-t) : 64'(t);
    t_mag    = t_abs[62:0];
    dv_sh    = {dv_rem, dv_num[63]};
    dv_ge    = dv_sh >= {1'b0, dv_den};
    sq_sh    = {sq_rem[32:0], sq_rad[63:62]};
    sq_trial = {s, 2'b01};
    sq_ge    = sq_sh >= {1'b0, sq_trial};
    if (!neg && dv_quo > 64'h7FFF_FFFF) begin
      g_sat = 32'sh7FFF_FFFF;
    end else if (neg && dv_quo > 64'h8000_0000) begin
      g_sat = 32'sh8000_0000;
    end else if (neg) begin
      g_sat = -$signed(dv_quo[31:0]);
    end else begin
      g_sat = $signed(dv_quo[31:0]);
    end
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      mem[fill_count[IW-1:0]] <= {in_data.x_value, in_data.grad_value};
    end
    rd_data <= mem[k[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      row_length  <= rrb_pkg::LenReset;
      eps_scaled  <= rrb_pkg::EpsReset;
      sum_squares <= '0;
      dot_sum     <= '0;
      fill_count  <= '0;
      out_valid   <= 1'b0;
      k           <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          rrb_pkg::REG_ROW_LENGTH: row_length <= cfg_data[rrb_pkg::LenWidth-1:0];
          rrb_pkg::REG_EPS_SCALED: eps_scaled <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != S_PUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            xr    <= in_data.x_value;
            gr    <= in_data.grad_value;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sum_squares <= sum_squares + VW'(sq_prod[30:0]);
          state       <= S_DOT;
        end
        S_DOT: begin
          dot_sum <= dot_sum + DW'(dot_prod);
          if (cnt_inc >= eff) begin
            n     <= cnt_inc;
            state <= S_VCALC;
          end else begin
            fill_count <= cnt_inc;
            state      <= S_IDLE;
          end
        end
        S_VCALC: begin
          v      <= sum_squares + VW'(n) * VW'(eps_scaled);
          k      <= '0;
          state  <= S_NDIV;
          dv_cnt <= '0;
          dv_rem <= '0;
        end
        S_NDIV: begin
          if (dv_cnt == 7'd0 && dv_rem == '0 && v == '0) begin
            s     <= '0;
            state <= S_RD;
          end else begin
            if (dv_cnt == 7'd0) begin
              dv_num <= {1'b0, v, 26'd0};
              dv_den <= 40'(n);
              dv_rem <= '0;
              dv_quo <= '0;
              dv_cnt <= 7'd64;
            end else begin
              dv_num <= {dv_num[62:0], 1'b0};
              dv_rem <= dv_ge ? 40'(dv_sh - {1'b0, dv_den}) : dv_sh[39:0];
              dv_quo <= {dv_quo[62:0], dv_ge};
              dv_cnt <= dv_cnt - 7'd1;
              if (dv_cnt == 7'd1) begin
                sq_rad <= {dv_quo[62:0], dv_ge};
                sq_rem <= '0;
                s      <= '0;
                dv_cnt <= 7'd32;
                state  <= S_SQRT;
              end
            end
          end
        end
        S_SQRT: begin
          sq_rad <= {sq_rad[61:0], 2'b00};
          sq_rem <= sq_ge ? 35'(sq_sh - {1'b0, sq_trial}) : sq_sh;
          s      <= {s[30:0], sq_ge};
          dv_cnt <= dv_cnt - 7'd1;
          if (dv_cnt == 7'd1) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          state <= S_MUL1;
        end
        S_MUL1: begin
          if (v == '0 || s == '0) begin
            neg    <= gm < 0;
            dv_quo <= (gm > 0) ? 64'h7FFF_FFFF : ((gm < 0) ? 64'h8000_0000 : 64'd0);
            state  <= S_PUT;
          end else begin
            p_gv  <= gm * $signed({1'b0, v});
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          t      <= t_next;
          dv_cnt <= '0;
          state  <= S_EDIV;
        end
        S_EDIV: begin
          if (dv_cnt == 7'd0) begin
            neg    <= t[54];
            dv_num <= {t_mag[55:0], 8'd0} + {t_mag[55:0], 8'd0} + 64'(v);
            dv_den <= {2'b00, v, 1'b0};
            dv_rem <= '0;
            dv_quo <= '0;
            dv_cnt <= 7'd64;
          end else begin
            dv_num <= {dv_num[62:0], 1'b0};
            dv_rem <= dv_ge ? 40'(dv_sh - {1'b0, dv_den}) : dv_sh[39:0];
            dv_quo <= {dv_quo[62:0], dv_ge};
            dv_cnt <= dv_cnt - 7'd1;
            if (dv_cnt == 7'd1) begin
              e_mag  <= {dv_quo[38:0], dv_ge};
              dv_cnt <= '0;
              state  <= S_GDIV;
            end
          end
        end
        S_GDIV: begin
          if (dv_cnt == 7'd0) begin
            dv_num <= {2'b00, e_mag, 22'd0} + 64'(s);
            dv_den <= {7'd0, s, 1'b0};
            dv_rem <= '0;
            dv_quo <= '0;
            dv_cnt <= 7'd64;
          end else begin
            dv_num <= {dv_num[62:0], 1'b0};
            dv_rem <= dv_ge ? 40'(dv_sh - {1'b0, dv_den}) : dv_sh[39:0];
            dv_quo <= {dv_quo[62:0], dv_ge};
            dv_cnt <= dv_cnt - 7'd1;
            if (dv_cnt == 7'd1) begin
              state <= S_PUT;
            end
          end
        end
        S_PUT: begin
          if (!out_valid || !out_stall) begin
            out_valid            <= 1'b1;
            out_data.grad_in     <= g_sat;
            out_data.last_of_row <= (k + CW'(1) == n);
            if (k + CW'(1) == n) begin
              sum_squares <= '0;
              dot_sum     <= '0;
              fill_count  <= '0;
              k           <= '0;
              state       <= S_IDLE;
            end else begin
              k     <= k + CW'(1);
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
